@@ hw/rtl/mtp_pkg.sv @@
// Shared constants, types and the tempering function of the Mersenne Twister generator.
package mtp_pkg;

   localparam int STATE_WORDS    = 624;
   localparam int SHIFT_DISTANCE = 397;
   localparam int IDX_W          = $clog2(STATE_WORDS + 1);
   localparam int WORD_W         = 32;

   typedef logic [WORD_W-1:0] word_type;
   typedef logic [IDX_W-1:0]  idx_type;

   localparam word_type TWIST_MATRIX = 32'h9908_B0DF;
   localparam word_type UPPER_MASK   = 32'h8000_0000;
   localparam word_type LOWER_MASK   = 32'h7FFF_FFFF;
   localparam word_type CHAIN_MULT   = 32'd69069;
   localparam word_type INIT_MULT    = 32'd1812433253;
   localparam word_type TEMPER_B     = 32'h9D2C_5680;
   localparam word_type TEMPER_C     = 32'h EFC6_0000;

   localparam idx_type LAST_WORD  = idx_type'(STATE_WORDS - 1);
   localparam idx_type FULL_COUNT = idx_type'(STATE_WORDS);
   localparam idx_type FAR_OFFSET = idx_type'(SHIFT_DISTANCE);
   localparam idx_type FAR_WRAP   = idx_type'(STATE_WORDS - SHIFT_DISTANCE);

   localparam logic [1:0] KIND_DRAW  = 2'd0;
   localparam logic [1:0] KIND_CHAIN = 2'd1;
   localparam logic [1:0] KIND_STD   = 2'd2;

   // One write port and two read ports with a shared read enable.
   typedef struct packed {
      logic     wr_en;
      idx_type  wr_addr;
      word_type wr_data;
      logic     rd_en;
      idx_type  rd_addr0;
      idx_type  rd_addr1;
   } store_req_type;

   function automatic word_type temper(input word_type w);
      word_type v;
      v = w;
      v = v ^ (v >> 11);
      v = v ^ ((v << 7) & TEMPER_B);
      v = v ^ ((v << 15) & TEMPER_C);
      v = v ^ (v >> 18);
      return v;
   endfunction

endpackage

@@ hw/rtl/mersenne_twister_prng.sv @@
// MT19937 generator top level: sequencer, word store and seed multiplier.
//
// A command word is taken when start is high and busy is low. req_kind selects
// a draw (0), a seed by the 69069 chain (1) or a seed by the standard
// initialisation (2); kind 3 is taken and ignored. req_seed_value is used by
// the seed kinds only.
// A draw gives one word on rsp_random_word, marked by rsp_valid for exactly one
// cycle; it follows the store read and the DRAW_OUT step, and busy falls in that
// cycle, so the next command is taken no earlier. The receiver cannot stall the result.
// When all 624 store words have been used, the draw first regenerates the
// store through the twist sequencer: a TW_PRE read, then a TW_RD read and a
// TW_WR write for each word, and then the draw read and output steps, with
// busy high throughout.
// A seed gives no result. It writes the seed word at acceptance and the other
// 623 words through the shared multiplier, each in a SEED_MUL and a SEED_WR
// step, and then twists the store with busy high throughout.
// Reset clears the sequencer and the read index; the store holds nothing
// meaningful until the first seed, and a draw before it returns undefined data.
module mersenne_twister_prng (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [1:0]          req_kind,
   input  mtp_pkg::word_type   req_seed_value,
   output logic                rsp_valid,
   output mtp_pkg::word_type   rsp_random_word
);
   import mtp_pkg::*;

   typedef enum logic [2:0] {
      IDLE,
      SEED_MUL,
      SEED_WR,
      TW_PRE,
      TW_RD,
      TW_WR,
      DRAW_RD,
      DRAW_OUT
   } state_type;

   state_type     state_ff;
   idx_type       k_ff;
   idx_type       read_index_ff;
   word_type      cur_ff;
   word_type      prev_ff;
   logic          std_ff;
   logic          draw_pend_ff;
   logic          rsp_valid_ff;
   word_type      rsp_word_ff;

   store_req_type store_req;
   word_type      rd_data0;
   word_type      rd_data1;
   word_type      mul_a;
   word_type      mul_b;
   word_type      product;

   logic          accept;
   idx_type       next_addr;
   idx_type       far_addr;
   idx_type       draw_addr;
   word_type      twist_y;
   word_type      twist_v;
   word_type      seed_v;

   assign accept = start && (state_ff == IDLE);
   assign busy   = (state_ff != IDLE);

   assign next_addr = (k_ff == LAST_WORD) ? '0 : k_ff + idx_type'(1);
   assign far_addr  = (k_ff >= FAR_WRAP) ? k_ff - FAR_WRAP : k_ff + FAR_OFFSET;
   assign draw_addr = FULL_COUNT - read_index_ff;

   assign twist_y = (cur_ff & UPPER_MASK) | (rd_data0 & LOWER_MASK);
   assign twist_v = rd_data1 ^ (twist_y >> 1) ^ (twist_y[0] ? TWIST_MATRIX : '0);

   assign mul_a  = std_ff ? (prev_ff ^ (prev_ff >> 30)) : prev_ff;
   assign mul_b  = std_ff ? INIT_MULT : CHAIN_MULT;
   assign seed_v = product + (std_ff ? {{(WORD_W-IDX_W){1'b0}}, k_ff} : '0);

   always_comb begin
      store_req          = '0;
      store_req.rd_addr0 = draw_addr;
      store_req.rd_addr1 = far_addr;
      unique case (state_ff)
         IDLE: begin
            if (accept && (req_kind == KIND_CHAIN || req_kind == KIND_STD)) begin
               store_req.wr_en   = 1'b1;
               store_req.wr_addr = '0;
               store_req.wr_data = req_seed_value;
            end else if (accept && req_kind == KIND_DRAW && read_index_ff != '0) begin
               store_req.rd_en = 1'b1;
            end
         end
         SEED_WR: begin
            store_req.wr_en   = 1'b1;
            store_req.wr_addr = k_ff;
            store_req.wr_data = seed_v;
         end
         TW_PRE: begin
            store_req.rd_en    = 1'b1;
            store_req.rd_addr0 = '0;
         end
         TW_RD: begin
            store_req.rd_en    = 1'b1;
            store_req.rd_addr0 = next_addr;
         end
         TW_WR: begin
            store_req.wr_en   = 1'b1;
            store_req.wr_addr = k_ff;
            store_req.wr_data = twist_v;
         end
         DRAW_RD: begin
            store_req.rd_en = 1'b1;
         end
         SEED_MUL, DRAW_OUT: begin
         end
      endcase
   end

   mtp_store u_store (
      .clock     (clock),
      .store_req (store_req),
      .rd_data0  (rd_data0),
      .rd_data1  (rd_data1)
   );

   mtp_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (product)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= IDLE;
         read_index_ff <= '0;
         draw_pend_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= (state_ff == DRAW_OUT);
         unique case (state_ff)
            IDLE: begin
               if (accept) begin
                  unique case (req_kind)
                     KIND_DRAW: begin
                        if (read_index_ff == '0) begin
                           draw_pend_ff <= 1'b1;
                           state_ff     <= TW_PRE;
                        end else begin
                           state_ff <= DRAW_OUT;
                        end
                     end
                     KIND_CHAIN, KIND_STD: begin
                        std_ff       <= (req_kind == KIND_STD);
                        prev_ff      <= req_seed_value;
                        k_ff         <= idx_type'(1);
                        draw_pend_ff <= 1'b0;
                        state_ff     <= SEED_MUL;
                     end
                     default: begin
                     end
                  endcase
               end
            end
            SEED_MUL: begin
               state_ff <= SEED_WR;
            end
            SEED_WR: begin
               prev_ff <= seed_v;
               if (k_ff == LAST_WORD) begin
                  state_ff <= TW_PRE;
               end else begin
                  k_ff     <= k_ff + idx_type'(1);
                  state_ff <= SEED_MUL;
               end
            end
            TW_PRE: begin
               k_ff     <= '0;
               state_ff <= TW_RD;
            end
            TW_RD: begin
               // The read data still holds the old value of the word being replaced.
               cur_ff   <= rd_data0;
               state_ff <= TW_WR;
            end
            TW_WR: begin
               if (k_ff == LAST_WORD) begin
                  read_index_ff <= FULL_COUNT;
                  state_ff      <= draw_pend_ff ? DRAW_RD : IDLE;
               end else begin
                  k_ff     <= next_addr;
                  state_ff <= TW_RD;
               end
            end
            DRAW_RD: begin
               draw_pend_ff <= 1'b0;
               state_ff     <= DRAW_OUT;
            end
            DRAW_OUT: begin
               rsp_word_ff   <= temper(rd_data0);
               read_index_ff <= read_index_ff - idx_type'(1);
               state_ff      <= IDLE;
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_random_word = rsp_word_ff;

`ifndef SYNTHESIS
   a_rsp_after_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == DRAW_OUT))
      else $error("result word without a draw output step");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for two cycles");

   a_draw_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_kind == KIND_DRAW) |=> busy)
      else $error("draw accepted without the block going busy");

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      read_index_ff <= FULL_COUNT)
      else $error("read index beyond the store size");

   a_no_write_on_draw: assert property (@(posedge clock) disable iff (reset)
      (state_ff == DRAW_OUT || state_ff == DRAW_RD) |-> !store_req.wr_en)
      else $error("store written during a draw read");
`endif

endmodule

@@ hw/rtl/mtp_store.sv @@
// Generator word store: one write port and two registered read ports.
module mtp_store (
   input  logic                  clock,
   input  mtp_pkg::store_req_type store_req,
   output mtp_pkg::word_type     rd_data0,
   output mtp_pkg::word_type     rd_data1
);
   import mtp_pkg::*;

   word_type mem [STATE_WORDS];
   word_type rd_data0_ff;
   word_type rd_data1_ff;

   always_ff @(posedge clock) begin
      if (store_req.wr_en) begin
         mem[store_req.wr_addr] <= store_req.wr_data;
      end
      if (store_req.rd_en) begin
         rd_data0_ff <= mem[store_req.rd_addr0];
         rd_data1_ff <= mem[store_req.rd_addr1];
      end
   end

   assign rd_data0 = rd_data0_ff;
   assign rd_data1 = rd_data1_ff;

endmodule

@@ hw/rtl/mtp_mul.sv @@
// Registered 32 by 32 multiplier keeping the low word of the product.
module mtp_mul (
   input  logic              clock,
   input  mtp_pkg::word_type op_a,
   input  mtp_pkg::word_type op_b,
   output mtp_pkg::word_type product
);
   import mtp_pkg::*;

   logic [2*WORD_W-1:0] full_prod;
   word_type            product_ff;

   assign full_prod = {{WORD_W{1'b0}}, op_a} * {{WORD_W{1'b0}}, op_b};

   always_ff @(posedge clock) begin
      product_ff <= full_prod[WORD_W-1:0];
   end

   assign product = product_ff;

endmodule

@@ dv/tb_mersenne_twister_prng.sv @@
// Self-checking testbench for the MT19937 generator: directed table, then random seed and draw runs.
module tb_mersenne_twister_prng;
   timeunit 1ns;
   timeprecision 1ps;

   import mtp_pkg::word_type;
   import mtp_pkg::KIND_DRAW;
   import mtp_pkg::KIND_CHAIN;
   import mtp_pkg::KIND_STD;

   localparam logic [1:0] KIND_NOP   = 2'd3;
   localparam int MT_WORDS           = 624;
   localparam int MT_SHIFT           = 397;
   localparam bit [31:0] MT_MATRIX   = 32'h9908_B0DF;
   localparam bit [31:0] MT_UPPER    = 32'h8000_0000;
   localparam bit [31:0] MT_LOWER    = 32'h7FFF_FFFF;
   localparam bit [31:0] MT_CHAIN_K  = 32'd69069;
   localparam bit [31:0] MT_INIT_K   = 32'd1812433253;
   localparam bit [31:0] MT_TEMPER_B = 32'h9D2C_5680;
   localparam bit [31:0] MT_TEMPER_C = 32'hEFC6_0000;
   localparam int RANDOM_ITEMS       = 1400;
   localparam int QUIET_TAIL         = 150;
   localparam int SETTLE_CYCLES      = 2600;
   localparam longint LIMIT_CYCLES   = 20_000_000;

   typedef struct {
      logic [1:0] kind;
      word_type   seed;
      bit         typed;
      word_type   want;
   } stim_row_type;

   logic       clock;
   logic       reset;
   logic       start;
   logic       busy;
   logic [1:0] req_kind;
   word_type   req_seed_value;
   logic       rsp_valid;
   word_type   rsp_random_word;

   bit [31:0]    mt_store [MT_WORDS];
   int unsigned  mt_unread;
   word_type     pending_words [$];
   stim_row_type directed_rows [$];
   int unsigned  mismatch_count;
   longint       cycle_count;

   mersenne_twister_prng DUT (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_kind        (req_kind),
      .req_seed_value  (req_seed_value),
      .rsp_valid       (rsp_valid),
      .rsp_random_word (rsp_random_word)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input word_type got, input word_type want);
      $display("mismatch at cycle %0d: %s got %08h want %08h", cycle_count, what, got, want);
      mismatch_count++;
   endtask

   // Standard MT19937 regeneration of the whole store.
   function automatic void regenerate_store();
      bit [31:0] y;
      bit [31:0] v;
      for (int k = 0; k < MT_WORDS; k++) begin
         y = (mt_store[k] & MT_UPPER) | (mt_store[(k + 1) % MT_WORDS] & MT_LOWER);
         v = mt_store[(k + MT_SHIFT) % MT_WORDS] ^ (y >> 1);
         if (y[0]) v = v ^ MT_MATRIX;
         mt_store[k] = v;
      end
      mt_unread = MT_WORDS;
   endfunction

   function automatic void seed_store(input logic [1:0] kind, input bit [31:0] seed);
      bit [31:0] p;
      mt_store[0] = seed;
      for (int k = 1; k < MT_WORDS; k++) begin
         p = mt_store[k - 1];
         if (kind == KIND_CHAIN) mt_store[k] = MT_CHAIN_K * p;
         else mt_store[k] = (MT_INIT_K * (p ^ (p >> 30))) + 32'(k);
      end
      regenerate_store();
   endfunction

   function automatic bit [31:0] draw_tempered();
      bit [31:0] v;
      if (mt_unread == 0) regenerate_store();
      v = mt_store[MT_WORDS - mt_unread];
      mt_unread--;
      v = v ^ (v >> 11);
      v = v ^ ((v << 7) & MT_TEMPER_B);
      v = v ^ ((v << 15) & MT_TEMPER_C);
      v = v ^ (v >> 18);
      return v;
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_word(input logic [1:0] kind, input word_type seed,
                            input bit typed = 1'b0, input word_type want = '0);
      bit [31:0] predicted;
      start          <= 1'b1;
      req_kind       <= kind;
      req_seed_value <= seed;
      @(posedge clock);
      while (busy) @(posedge clock);
      case (kind)
         KIND_DRAW: begin
            predicted = draw_tempered();
            pending_words.push_back(typed ? want : word_type'(predicted));
         end
         KIND_CHAIN, KIND_STD: seed_store(kind, seed);
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic pause_sender(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   task automatic add_row(input logic [1:0] kind, input word_type seed,
                          input bit typed = 1'b0, input word_type want = '0);
      stim_row_type row;
      row.kind  = kind;
      row.seed  = seed;
      row.typed = typed;
      row.want  = want;
      directed_rows.push_back(row);
   endtask

   function automatic word_type pick_seed();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2: return 32'h8000_0000;
         default: return $urandom;
      endcase
   endfunction

   always @(posedge clock) begin : check_results
      word_type want;
      if (!reset && rsp_valid) begin
         if (pending_words.size() == 0) begin
            report_mismatch("unexpected word", rsp_random_word, '0);
         end else begin
            want = pending_words.pop_front();
            if (rsp_random_word !== want) report_mismatch("random_word", rsp_random_word, want);
         end
      end
   end

   initial begin : stimulus
      int unsigned issued;
      int unsigned run_length;
      int          idle_pct;
      bit          first_run;
      bit          drained;

      mismatch_count = 0;
      cycle_count    = 0;
      mt_unread      = 0;
      foreach (mt_store[k]) mt_store[k] = '0;
      reset          = 1'b1;
      start          = 1'b0;
      req_kind       = KIND_DRAW;
      req_seed_value = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // A zero chain seed leaves an all-zero store, and twisting zeros gives zeros.
      add_row(KIND_NOP, '1);
      add_row(KIND_CHAIN, '0);
      add_row(KIND_DRAW, '0, 1'b1, '0);
      add_row(KIND_DRAW, '1, 1'b1, '0);
      // The customary default seed.
      add_row(KIND_STD, 32'd5489);
      add_row(KIND_DRAW, '0);
      add_row(KIND_DRAW, '1);
      add_row(KIND_NOP, 32'h5A5A_A5A5);
      add_row(KIND_DRAW, 32'hA5A5_5A5A);
      add_row(KIND_CHAIN, '1);
      add_row(KIND_DRAW, '0);
      add_row(KIND_DRAW, '0);
      add_row(KIND_STD, '0);
      add_row(KIND_DRAW, '1);
      add_row(KIND_STD, '1);
      add_row(KIND_DRAW, '0);
      add_row(KIND_CHAIN, 32'd1);
      add_row(KIND_DRAW, '0);
      add_row(KIND_STD, 32'h8000_0000);
      add_row(KIND_DRAW, '0);
      add_row(KIND_CHAIN, 32'h7FFF_FFFF);
      add_row(KIND_DRAW, '0);
      add_row(KIND_DRAW, '0);

      foreach (directed_rows[i]) begin
         send_word(directed_rows[i].kind, directed_rows[i].seed,
                   directed_rows[i].typed, directed_rows[i].want);
         if ($urandom_range(0, 2) == 0) pause_sender($urandom_range(1, 5));
      end

      // Random runs: a seed followed by a stream of draws. Some runs go past the
      // end of the store so that a draw has to regenerate it first.
      issued    = 0;
      first_run = 1'b1;
      drained   = 1'b0;
      while (issued < RANDOM_ITEMS) begin
         send_word($urandom_range(0, 1) ? KIND_CHAIN : KIND_STD, pick_seed());
         issued++;
         if (first_run) run_length = $urandom_range(650, 720);
         else if ($urandom_range(0, 9) == 0) run_length = $urandom_range(625, 700);
         else run_length = $urandom_range(0, 40);
         first_run = 1'b0;
         case ($urandom_range(0, 2))
            0: idle_pct = 0;
            1: idle_pct = 15;
            default: idle_pct = 50;
         endcase
         for (int n = 0; n < run_length && issued < RANDOM_ITEMS; n++) begin
            if (issued < RANDOM_ITEMS - QUIET_TAIL) begin
               if ($urandom_range(0, 99) < idle_pct) pause_sender($urandom_range(1, 5));
               if ($urandom_range(0, 99) < 3) send_word(KIND_NOP, $urandom);
            end
            send_word(KIND_DRAW, $urandom);
            issued++;
            // Once, at the halfway point of the random items, hold off until every outstanding word has come back.
            if (!drained && issued >= RANDOM_ITEMS / 2) begin
               start <= 1'b0;
               while (pending_words.size() != 0) @(negedge clock);
               drained = 1'b1;
            end
         end
      end

      start <= 1'b0;
      while (pending_words.size() != 0) @(negedge clock);
      // A trailing seed can still keep the block busy, so wait for it to settle.
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
